### hdl/crlm_pkg.sv
// Shared types and constants for the processor range list parser.
// No dependencies; imported by cpu_range_list_to_mask, crlm_checker and the testbench top.
`timescale 1ns / 1ps
`default_nettype none

package crlm_pkg;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // accumulator saturates here, above any processor index
  localparam logic [6:0] ACC_MAX = 7'd127;
  localparam logic [3:0] RADIX   = 4'd10;

  typedef enum logic [1:0] {
    ROLE_NONE = 2'd0,
    ROLE_LOW  = 2'd1,
    ROLE_HIGH = 2'd2
  } role_t;

  typedef struct packed {
    logic [5:0] low_bound;
    logic [5:0] high_bound;
    logic       low_seen;
    logic       high_seen;
    logic       dash_seen;
    logic [6:0] digit_value;
    role_t      number_role;
  } token_t;

endpackage

`default_nettype wire

### hdl/cpu_range_list_to_mask.sv
// Processor range list parser: turns "0-3,7,9-" text into a processor mask.
// Depends on crlm_pkg for character codes, role codes and the token type.
//
//   channel | dir | ports                 | payload
//   in      | in  | in_tvalid/in_tready   | in_tdata = char_code[7:0], in_tlast = is_last
//   out     | out | out_tvalid/out_tready | out_tdata = cpu_mask[63:0], out_tuser = parse_error
//   cfg     | in  | cfg_we                | cfg_wdata = highest_cpu[5:0]
//
// One character is taken per cycle while in_tready is high; the token state updates
// in the same cycle through the digit accumulate and range fill logic.
// The result for tlast goes to the output register, or to the skid entry while out stalls.
// A two-deep output (output register plus skid entry) keeps in_tready high while
// one result waits; in_tready drops only while the skid entry is occupied.
// Synchronous active-low reset clears the list state and sets highest_cpu to 63.
`timescale 1ns / 1ps
`default_nettype none

module cpu_range_list_to_mask #(
  parameter int MASK_BITS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] char_code
  input  wire         in_tlast,   // is_last
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // [63:0] cpu_mask
  output logic        out_tuser,  // [0] parse_error
  input  wire         cfg_we,
  input  wire  [5:0]  cfg_wdata   // [5:0] highest_cpu
);

  import crlm_pkg::*;

  localparam logic [5:0] LIM_MAX = 6'(MASK_BITS - 1);

  logic [5:0]           highest_cpu_r;
  logic [MASK_BITS-1:0] mask_r, mask_nxt;
  token_t               tok_r, tok_nxt;
  logic                 err_r, err_nxt;

  logic                 out_valid_r, skd_valid_r;
  logic [63:0]          out_mask_r, skd_mask_r;
  logic                 out_err_r, skd_err_r;

  logic                 in_fire, out_fire, res_valid;
  logic [63:0]          res_mask;
  logic                 res_err;
  logic [5:0]           limit;
  logic                 is_digit;
  logic [10:0]          acc;

  assign in_tready  = !skd_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign res_valid  = in_fire && in_tlast;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mask_r;
  assign out_tuser  = out_err_r;

  assign limit    = (highest_cpu_r > LIM_MAX) ? LIM_MAX : highest_cpu_r;
  assign is_digit = (in_tdata >= CHAR_ZERO) && (in_tdata <= CHAR_NINE);
  assign acc      = {4'd0, tok_r.digit_value} * {7'd0, RADIX} + {7'd0, in_tdata[3:0]};

  always_comb begin
    token_t      t;
    logic        err;
    logic        used;
    logic        close_tok;
    logic [5:0]  lo;
    logic [5:0]  hi;
    logic        fill_ok;
    logic [63:0] fill;
    logic [MASK_BITS-1:0] mask;

    t         = tok_r;
    err       = err_r;
    mask      = mask_r;
    used      = 1'b0;
    close_tok = 1'b0;
    lo        = '0;
    hi        = '0;
    fill_ok   = 1'b0;
    fill      = '0;

    if (!err) begin
      if (t.number_role != ROLE_NONE) begin
        if (is_digit) begin
          t.digit_value = (acc > {4'd0, ACC_MAX}) ? ACC_MAX : acc[6:0];
          used = 1'b1;
        end else begin
          // close the number at the first non-digit
          if (t.digit_value > {1'b0, limit}) begin
            err = 1'b1;
          end else if (t.number_role == ROLE_LOW) begin
            t.low_bound = t.digit_value[5:0];
            t.low_seen  = 1'b1;
          end else begin
            t.high_bound = t.digit_value[5:0];
            t.high_seen  = 1'b1;
          end
          t.number_role = ROLE_NONE;
          t.digit_value = '0;
        end
      end
      if (!used && !err) begin
        if (in_tdata == CHAR_COMMA) begin
          close_tok = 1'b1;
        end else if (in_tdata == CHAR_DASH) begin
          t.dash_seen = 1'b1;
          if (!t.low_seen) begin
            t.low_bound = '0;
            t.low_seen  = 1'b1;
          end
        end else if (!t.low_seen || (t.dash_seen && !t.high_seen)) begin
          if (is_digit) begin
            t.number_role = t.low_seen ? ROLE_HIGH : ROLE_LOW;
            t.digit_value = {3'd0, in_tdata[3:0]};
          end else begin
            err = 1'b1;
          end
        end
        // otherwise skip the character after a finished number
      end
    end

    if (in_tlast) begin
      if (!err && t.number_role != ROLE_NONE) begin
        if (t.digit_value > {1'b0, limit}) begin
          err = 1'b1;
        end else if (t.number_role == ROLE_LOW) begin
          t.low_bound = t.digit_value[5:0];
          t.low_seen  = 1'b1;
        end else begin
          t.high_bound = t.digit_value[5:0];
          t.high_seen  = 1'b1;
        end
        t.number_role = ROLE_NONE;
        t.digit_value = '0;
      end
      if (!err) begin
        close_tok = 1'b1;
      end
    end

    if (close_tok) begin
      if (t.dash_seen) begin
        lo      = t.low_seen ? t.low_bound : 6'd0;
        hi      = t.high_seen ? t.high_bound : limit;
        fill_ok = 1'b1;
      end else if (t.low_seen) begin
        lo      = t.low_bound;
        hi      = t.low_bound;
        fill_ok = 1'b1;
      end
      if (fill_ok && (lo <= hi)) begin
        fill = ({64{1'b1}} >> (6'd63 - hi)) & ({64{1'b1}} << lo);
      end
      mask = mask | fill[MASK_BITS-1:0];
      t    = '{number_role: ROLE_NONE, default: '0};
    end

    res_err  = err;
    res_mask = err ? 64'd0 : 64'(mask);

    if (in_tlast) begin
      tok_nxt  = '{number_role: ROLE_NONE, default: '0};
      err_nxt  = 1'b0;
      mask_nxt = '0;
    end else begin
      tok_nxt  = t;
      err_nxt  = err;
      mask_nxt = mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_cpu_r <= 6'd63;
      tok_r         <= '{number_role: ROLE_NONE, default: '0};
      err_r         <= 1'b0;
      mask_r        <= '0;
      out_valid_r   <= 1'b0;
      skd_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        highest_cpu_r <= cfg_wdata;
      end
      if (in_fire) begin
        tok_r  <= tok_nxt;
        err_r  <= err_nxt;
        mask_r <= mask_nxt;
      end
      if (!out_valid_r || out_fire) begin
        // refill the output register: skid entry first, then a fresh result
        if (skd_valid_r) begin
          out_valid_r <= 1'b1;
          skd_valid_r <= 1'b0;
        end else begin
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        skd_valid_r <= 1'b1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skd_valid_r) begin
        out_mask_r <= skd_mask_r;
        out_err_r  <= skd_err_r;
      end else if (res_valid) begin
        out_mask_r <= res_mask;
        out_err_r  <= res_err;
      end
    end else if (res_valid) begin
      skd_mask_r <= res_mask;
      skd_err_r  <= res_err;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_error_zero_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_mask_r == 64'd0))
    else $error("error result carries a nonzero mask");

  a_list_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (tok_r.number_role == ROLE_NONE) && !err_r && (mask_r == '0))
    else $error("list state not cleared after last character");

  a_number_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_r.number_role != ROLE_NONE) |-> !err_r)
    else $error("number in progress while error flag set");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && res_valid) |=> skd_valid_r)
    else $error("result lost while output stalled");

endmodule

`default_nettype wire

### sim/crlm_checker.sv
// Checker for cpu_range_list_to_mask: watches the in, out and cfg ports,
// parses each transfer in its own list parser and compares every result.
// Depends on crlm_pkg for character codes and role codes.
`timescale 1ns / 1ps

module crlm_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [7:0]  in_tdata,
  input  wire         in_tlast,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [63:0] out_tdata,
  input  wire         out_tuser,
  input  wire         cfg_we,
  input  wire  [5:0]  cfg_wdata,
  output int          mismatches,
  output int          outstanding
);

  import crlm_pkg::*;

  typedef struct packed {
    logic [63:0] mask;
    logic        err;
  } list_result_t;

  list_result_t pending_masks[$];

  logic [5:0]  cpu_top;
  logic [63:0] mask_acc;
  logic [6:0]  lo_b;
  logic [6:0]  hi_b;
  logic        lo_seen;
  logic        hi_seen;
  logic        dash_seen;
  logic [6:0]  acc;
  role_t       role;
  logic        list_err;
  int          fail_cnt;

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    if (fail_cnt < 30) begin
      $display("crlm_checker: %s mismatch at %0t: expected %h, got %h", what, $time, want, got);
    end
    fail_cnt++;
  endtask

  task automatic clear_token();
    lo_b = '0;
    hi_b = '0;
    lo_seen = 1'b0;
    hi_seen = 1'b0;
    dash_seen = 1'b0;
    acc = '0;
    role = ROLE_NONE;
  endtask

  task automatic clear_list();
    clear_token();
    mask_acc = '0;
    list_err = 1'b0;
  endtask

  task automatic close_number();
    if (acc > {1'b0, cpu_top}) begin
      list_err = 1'b1;
    end else if (role == ROLE_LOW) begin
      lo_b = acc;
      lo_seen = 1'b1;
    end else begin
      hi_b = acc;
      hi_seen = 1'b1;
    end
    role = ROLE_NONE;
    acc = '0;
  endtask

  task automatic close_token();
    logic [6:0] lo;
    logic [6:0] hi;
    if (dash_seen) begin
      lo = lo_seen ? lo_b : 7'd0;
      hi = hi_seen ? hi_b : {1'b0, cpu_top};
    end else if (lo_seen) begin
      lo = lo_b;
      hi = lo_b;
    end else begin
      clear_token();
      return;
    end
    // reversed range sets nothing
    if (lo[5:0] <= hi[5:0]) begin
      mask_acc |= ({64{1'b1}} >> (6'd63 - hi[5:0])) & ({64{1'b1}} << lo[5:0]);
    end
    clear_token();
  endtask

  task automatic take_char(input logic [7:0] c);
    logic       is_digit;
    logic [10:0] sum;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (role != ROLE_NONE) begin
      if (is_digit) begin
        sum = 11'(acc) * 11'(RADIX) + 11'(c - CHAR_ZERO);
        acc = (sum > 11'(ACC_MAX)) ? ACC_MAX : sum[6:0];
        return;
      end
      close_number();
      if (list_err) return;
    end
    if (c == CHAR_COMMA) begin
      close_token();
    end else if (c == CHAR_DASH) begin
      dash_seen = 1'b1;
      if (!lo_seen) begin
        lo_b = '0;
        lo_seen = 1'b1;
      end
    end else if (!lo_seen || (dash_seen && !hi_seen)) begin
      if (is_digit) begin
        role = lo_seen ? ROLE_HIGH : ROLE_LOW;
        acc = 7'(c - CHAR_ZERO);
      end else begin
        list_err = 1'b1;
      end
    end
    // anything else follows a finished number: skip it
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    if (!list_err) take_char(c);
    if (last) begin
      if (!list_err && role != ROLE_NONE) close_number();
      if (!list_err) close_token();
      pending_masks.push_back(list_result_t'{list_err ? 64'd0 : mask_acc, list_err});
      clear_list();
    end
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      cpu_top = 6'd63;
      clear_list();
      pending_masks.delete();
    end else begin
      // check the out side first: a transfer here never belongs to this edge's input
      if (out_tvalid && out_tready) begin
        if (pending_masks.size() == 0) begin
          report("unexpected result", 64'd0, out_tdata);
        end else begin
          want = pending_masks.pop_front();
          if (out_tdata !== want.mask) report("cpu_mask", want.mask, out_tdata);
          if (out_tuser !== want.err) report("parse_error", 64'(want.err), 64'(out_tuser));
        end
      end
      if (in_tvalid && in_tready) parse_char(in_tdata, in_tlast);
      if (cfg_we) cpu_top = cfg_wdata;
    end
    mismatches  <= fail_cnt;
    outstanding <= pending_masks.size();
  end

endmodule

### sim/tb_cpu_range_list_to_mask.sv
// Testbench top for cpu_range_list_to_mask: makes range list text, config
// writes and receiver stalls, then gives the verdict from crlm_checker.
// Depends on crlm_pkg, cpu_range_list_to_mask and crlm_checker.
`timescale 1ns / 1ps

module tb_cpu_range_list_to_mask;
  import crlm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = 6'd0;

  int          mismatches;
  int          outstanding;
  int          cycle_cnt = 0;
  int          chars_sent = 0;
  int          cpu_top = 63;
  bit          idle_on = 1'b0;
  bit          stall_on = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;
  logic [7:0]  text[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cpu_range_list_to_mask u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  crlm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_cpu_range_list_to_mask: done, errors");
      $finish;
    end
  end

  // receiver: long hold on request, random stall bursts otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic send_list(input string s);
    text.delete();
    put_str(s);
    send_text();
  endtask

  function automatic int pick_num();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(cpu_top + 1, 999);
    if (r == 1) return cpu_top;
    if (r == 2) return 0;
    return $urandom_range(0, cpu_top);
  endfunction

  task automatic put_num(input int v);
    if ($urandom_range(0, 15) == 0) text.push_back(CHAR_ZERO);
    put_str($sformatf("%0d", v));
  endtask

  // mostly well-formed lists with random bounds; some junk and some corruption
  task automatic build_list();
    int mode;
    int ntok;
    int form;
    int pos;
    text.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ntok = $urandom_range(1, 5);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) text.push_back(CHAR_COMMA);
      form = $urandom_range(0, 7);
      case (form)
        0: put_num(pick_num());
        1: begin
          put_num(pick_num());
          text.push_back(CHAR_DASH);
          put_num(pick_num());
        end
        2: begin
          text.push_back(CHAR_DASH);
          put_num(pick_num());
        end
        3: begin
          put_num(pick_num());
          text.push_back(CHAR_DASH);
        end
        4: text.push_back(CHAR_DASH);
        5: ;
        6: begin
          put_num(pick_num());
          text.push_back(CHAR_DASH);
          put_num(pick_num());
          text.push_back(CHAR_DASH);
          put_num(pick_num());
        end
        default: begin
          put_num(pick_num());
          text.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) text.push_back(CHAR_COMMA);
    if (text.size() == 0) text.push_back(CHAR_COMMA);
    if (mode == 1) begin
      pos = $urandom_range(0, text.size() - 1);
      text[pos] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic run_lists(input int count, input bit quiet);
    int stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      idle_on  = !quiet && $urandom_range(0, 3) != 0;
      stall_on = !quiet && $urandom_range(0, 3) != 0;
      build_list();
      send_text();
    end
  endtask

  // hold off until every result is back, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= 6'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cpu_top = v;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lists at the reset limit of 63
    send_list("0-3,,7,9-");
    send_list("-");
    send_list(" 5");
    send_list("+1");
    text.delete();
    text.push_back(8'h00);
    send_text();
    send_list("999");
    send_list("5-2");
    send_list("3x");
    send_list("64");
    text.delete();
    text.push_back(8'hFF);
    send_text();

    set_limit(63);
    run_lists(200, 1'b0);

    set_limit(0);
    run_lists(150, 1'b0);

    // long receiver hold while the sender keeps offering
    idle_on = 1'b0;
    hold_req <= ~hold_req;
    repeat (30) send_list($urandom_range(0, 1) ? "0" : "-");
    drain();

    set_limit($urandom_range(1, 62));
    run_lists(250, 1'b0);
    set_limit(7);
    run_lists(200, 1'b0);
    set_limit(31);
    run_lists(200, 1'b0);
    set_limit(63);
    run_lists(200, 1'b1);

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_cpu_range_list_to_mask: done, clean");
    end else begin
      $display("tb_cpu_range_list_to_mask: done, errors");
    end
    $finish;
  end

endmodule
